[rtl/pwt_pkg.sv]
`default_nettype none
package pwt_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned FieldW  = 61;
  localparam int unsigned WireW   = 3;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned KindW   = 2;
  localparam int unsigned CodeW   = 2;
  localparam int unsigned CountW  = 4;
  localparam int unsigned OutDataW = 144;
  localparam int unsigned OutPadW  = OutDataW - FieldW - WireW - ValueW - ByteW - CodeW;

  // last byte index of a ten-byte varint
  localparam logic [CountW-1:0] VarintLastIdx = CountW'(9);
  localparam logic [ValueW-1:0] Fixed64Len = ValueW'(8);
  localparam logic [ValueW-1:0] Fixed32Len = ValueW'(4);

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_VARINT  = 3'd1,
    PH_FIXED   = 3'd2,
    PH_LENGTH  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DROP    = 3'd5
  } phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_SCALAR  = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  typedef enum logic [CodeW-1:0] {
    ERR_TRUNCATED = 2'd0,
    ERR_TOO_LONG  = 2'd1,
    ERR_PAST_END  = 2'd2,
    ERR_WIRE_TYPE = 2'd3
  } err_e;

  typedef enum logic [WireW-1:0] {
    WT_VARINT  = 3'd0,
    WT_FIXED64 = 3'd1,
    WT_LEN     = 3'd2,
    WT_SGROUP  = 3'd3,
    WT_EGROUP  = 3'd4,
    WT_FIXED32 = 3'd5
  } wire_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last;
  } in_item_t;

  typedef struct packed {
    kind_e             kind;
    logic [FieldW-1:0] field_number;
    logic [WireW-1:0]  wire_type;
    logic [ValueW-1:0] value;
    logic [ByteW-1:0]  payload_byte;
    err_e              error_code;
    logic              end_of_message;
  } result_t;

endpackage
`default_nettype wire

[rtl/pwt_in_reg.sv]
`default_nettype none
module pwt_in_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire pwt_pkg::in_item_t item_i,
  input  wire logic              take_i,
  output logic                   valid_o,
  output pwt_pkg::in_item_t      item_o
);
  import pwt_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;

  // slot frees when the held request is consumed this cycle
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (valid_i && ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule
`default_nettype wire

[rtl/pwt_decode.sv]
`default_nettype none
module pwt_decode (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire pwt_pkg::in_item_t item_i,
  output logic                   res_valid_o,
  output pwt_pkg::result_t       res_o
);
  import pwt_pkg::*;

  phase_e             phase_q, phase_d;
  logic [ValueW-1:0]  acc_q, acc_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [FieldW-1:0]  fnum_q, fnum_d;
  logic [WireW-1:0]   wt_q, wt_d;
  logic [ValueW-1:0]  rem_q, rem_d;

  logic [ByteW-1:0]   b;
  logic               last;
  logic [ValueW-1:0]  var_acc;
  logic [ValueW-1:0]  fix_acc;
  logic [6:0]         var_shift;
  logic               var_more;
  logic               var_long;
  logic               fail;
  err_e               fail_code;

  assign b         = item_i.data_byte;
  assign last      = item_i.last;
  assign var_shift = 7'(cnt_q) * 7'd7;
  assign var_acc   = acc_q | (ValueW'(b[6:0]) << var_shift);
  assign fix_acc   = acc_q | (ValueW'(b) << {cnt_q[2:0], 3'b000});
  assign var_more  = b[7];
  assign var_long  = var_more && (cnt_q == VarintLastIdx);

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    fnum_d      = fnum_q;
    wt_d        = wt_q;
    rem_d       = rem_q;
    fail        = 1'b0;
    fail_code   = ERR_TRUNCATED;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.end_of_message = last;

    unique case (phase_q)
      PH_TAG: begin
        if (var_long) begin
          fail      = 1'b1;
          fail_code = ERR_TOO_LONG;
        end else if (var_more) begin
          acc_d = var_acc;
          cnt_d = cnt_q + 1'b1;
          if (last) begin
            fail      = 1'b1;
            fail_code = ERR_TRUNCATED;
          end
        end else begin
          fnum_d = var_acc[ValueW-1:WireW];
          wt_d   = var_acc[WireW-1:0];
          acc_d  = '0;
          cnt_d  = '0;
          unique case (wire_e'(var_acc[WireW-1:0]))
            WT_VARINT:  phase_d = PH_VARINT;
            WT_FIXED64: begin
              phase_d = PH_FIXED;
              rem_d   = Fixed64Len;
            end
            WT_LEN:     phase_d = PH_LENGTH;
            WT_FIXED32: begin
              phase_d = PH_FIXED;
              rem_d   = Fixed32Len;
            end
            default: begin
              fail      = 1'b1;
              fail_code = ERR_WIRE_TYPE;
            end
          endcase
          if (!fail && last) begin
            fail = 1'b1;
            if (var_acc[WireW-1:0] == WT_FIXED64 || var_acc[WireW-1:0] == WT_FIXED32) begin
              fail_code = ERR_PAST_END;
            end else begin
              fail_code = ERR_TRUNCATED;
            end
          end
        end
      end
      PH_VARINT, PH_LENGTH: begin
        if (var_long) begin
          fail      = 1'b1;
          fail_code = ERR_TOO_LONG;
        end else if (var_more) begin
          acc_d = var_acc;
          cnt_d = cnt_q + 1'b1;
          if (last) begin
            fail      = 1'b1;
            fail_code = ERR_TRUNCATED;
          end
        end else begin
          acc_d = '0;
          cnt_d = '0;
          res_o.field_number = fnum_q;
          res_o.value        = var_acc;
          if (phase_q == PH_VARINT) begin
            phase_d           = PH_TAG;
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_SCALAR;
            res_o.wire_type   = wt_q;
          end else if (var_acc == '0) begin
            phase_d           = PH_TAG;
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_HEADER;
            res_o.wire_type   = WT_LEN;
          end else if (last) begin
            fail      = 1'b1;
            fail_code = ERR_PAST_END;
          end else begin
            phase_d           = PH_PAYLOAD;
            rem_d             = var_acc;
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_HEADER;
            res_o.wire_type   = WT_LEN;
          end
        end
      end
      PH_FIXED: begin
        // remaining count is never zero while collecting fixed bytes
        if (rem_q == ValueW'(1)) begin
          acc_d             = '0;
          cnt_d             = '0;
          rem_d             = '0;
          phase_d           = PH_TAG;
          res_valid_o       = 1'b1;
          res_o.kind        = KIND_SCALAR;
          res_o.field_number = fnum_q;
          res_o.wire_type   = wt_q;
          res_o.value       = fix_acc;
        end else begin
          acc_d = fix_acc;
          cnt_d = cnt_q + 1'b1;
          rem_d = rem_q - 1'b1;
          if (last) begin
            fail      = 1'b1;
            fail_code = ERR_PAST_END;
          end
        end
      end
      PH_PAYLOAD: begin
        rem_d = rem_q - 1'b1;
        if (rem_q == ValueW'(1)) begin
          phase_d = PH_TAG;
        end
        if (rem_q != ValueW'(1) && last) begin
          fail      = 1'b1;
          fail_code = ERR_PAST_END;
        end else begin
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_PAYLOAD;
          res_o.field_number = fnum_q;
          res_o.wire_type    = WT_LEN;
          res_o.payload_byte = b;
        end
      end
      default: begin
        // drop until the region ends
        if (last) begin
          phase_d = PH_TAG;
          acc_d   = '0;
          cnt_d   = '0;
          rem_d   = '0;
        end
      end
    endcase

    if (fail) begin
      phase_d     = last ? PH_TAG : PH_DROP;
      acc_d       = '0;
      cnt_d       = '0;
      rem_d       = '0;
      res_valid_o = 1'b1;
      res_o       = '0;
      res_o.kind  = KIND_ERROR;
      res_o.error_code     = fail_code;
      res_o.end_of_message = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      acc_q   <= '0;
      cnt_q   <= '0;
      fnum_q  <= '0;
      wt_q    <= '0;
      rem_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      fnum_q  <= fnum_d;
      wt_q    <= wt_d;
      rem_q   <= rem_d;
    end
  end
endmodule
`default_nettype wire

[rtl/pwt_out_reg.sv]
`default_nettype none
module pwt_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire logic             res_valid_i,
  input  wire pwt_pkg::result_t res_i,
  output logic                  free_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output pwt_pkg::result_t      res_o
);
  import pwt_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;
  logic    load;

  assign free_o = !valid_q || ready_i;
  assign load   = fire_i && res_valid_i;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
endmodule
`default_nettype wire

[rtl/protobuf_wire_tokenizer.sv]
// protobuf wire tokenizer: one encoded byte per request in, at most one token out
// datapath: each byte is held in the input register and decoded once the output register is free,
// and the resulting token is registered in the output register
// throughput: one byte per cycle while the token output is not stalled by m_axis_tready_i
// reset: asynchronous, active low; clears the decoder to expect a new tag
`default_nettype none
module protobuf_wire_tokenizer (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  wire logic [pwt_pkg::ByteW-1:0]        s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic                             s_axis_tlast_i,  // last
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // [60:0] field_number, [63:61] wire_type, [127:64] value,
  // [135:128] payload_byte, [137:136] error_code, [143:138] zero
  output logic [pwt_pkg::OutDataW-1:0]          m_axis_tdata_o,
  output logic [pwt_pkg::KindW-1:0]             m_axis_tuser_o,  // [1:0] kind
  output logic                                  m_axis_tlast_o   // end_of_message
);
  import pwt_pkg::*;

  in_item_t in_item;
  in_item_t held_item;
  logic     held_valid;
  logic     out_free;
  logic     fire;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  assign in_item.data_byte = s_axis_tdata_i;
  assign in_item.last      = s_axis_tlast_i;
  assign fire              = held_valid && out_free;

  pwt_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .take_i  (fire),
    .valid_o (held_valid),
    .item_o  (held_item)
  );

  pwt_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (held_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pwt_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .res_o       (out_res)
  );

  assign m_axis_tdata_o = {{OutPadW{1'b0}}, out_res.error_code, out_res.payload_byte,
                           out_res.value, out_res.wire_type, out_res.field_number};
  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tlast_o = out_res.end_of_message;
endmodule
`default_nettype wire

[tb/pwt_token_checker.sv]
`timescale 1ns / 100ps
module pwt_token_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  input  logic                         req_ready_i,
  input  logic [pwt_pkg::ByteW-1:0]    req_byte_i,
  input  logic                         req_last_i,
  input  logic                         tok_valid_i,
  input  logic                         tok_ready_i,
  input  logic [pwt_pkg::OutDataW-1:0] tok_data_i,
  input  logic [pwt_pkg::KindW-1:0]    tok_kind_i,
  input  logic                         tok_last_i,
  output int                           mismatches_o,
  output int                           outstanding_o
);
  import pwt_pkg::*;

  typedef enum logic [1:0] {
    VARINT_MORE,
    VARINT_DONE,
    VARINT_LONG
  } varint_step_e;

  // code field reads zero outside error tokens
  localparam err_e NoError = ERR_TRUNCATED;

  phase_e            decode_phase = PH_TAG;
  logic [ValueW-1:0] accum = '0;
  logic [CountW-1:0] varint_len = '0;
  logic [FieldW-1:0] held_field = '0;
  logic [WireW-1:0]  held_wire = '0;
  logic [ValueW-1:0] remaining = '0;
  result_t           expected_tokens[$];

  function automatic varint_step_e take_varint(input logic [ByteW-1:0] b);
    int shift;
    shift = 7 * (varint_len % 10);
    accum |= ValueW'(b[6:0]) << shift;
    if (!b[7]) return VARINT_DONE;
    varint_len++;
    if (varint_len >= 10) return VARINT_LONG;
    return VARINT_MORE;
  endfunction

  function automatic void push_token(input kind_e k, input logic [FieldW-1:0] fn,
                                     input logic [WireW-1:0] wt, input logic [ValueW-1:0] v,
                                     input logic [ByteW-1:0] pb, input err_e code,
                                     input logic eom);
    result_t t;
    t.kind           = k;
    t.field_number   = fn;
    t.wire_type      = wt;
    t.value          = v;
    t.payload_byte   = pb;
    t.error_code     = code;
    t.end_of_message = eom;
    expected_tokens.insert(expected_tokens.size(), t);
  endfunction

  function automatic void raise_error(input err_e code, input logic eom);
    if (eom) begin
      decode_phase = PH_TAG;
    end else begin
      decode_phase = PH_DROP;
    end
    accum      = '0;
    varint_len = '0;
    remaining  = '0;
    push_token(KIND_ERROR, '0, '0, '0, '0, code, eom);
  endfunction

  function automatic string token_text(input result_t t);
    return $sformatf("kind=%0d field=%h wire=%0d value=%h byte=%h code=%0d eom=%0d",
                     t.kind, t.field_number, t.wire_type, t.value, t.payload_byte,
                     t.error_code, t.end_of_message);
  endfunction

  task automatic decode_byte(input logic [ByteW-1:0] b, input logic eom);
    varint_step_e      st;
    logic [ValueW-1:0] v;
    case (decode_phase)
      PH_TAG: begin
        st = take_varint(b);
        if (st == VARINT_LONG) begin
          raise_error(ERR_TOO_LONG, eom);
        end else if (st == VARINT_MORE) begin
          if (eom) raise_error(ERR_TRUNCATED, eom);
        end else begin
          held_field = accum[ValueW-1:WireW];
          held_wire  = accum[WireW-1:0];
          accum      = '0;
          varint_len = '0;
          case (held_wire)
            WT_VARINT:  decode_phase = PH_VARINT;
            WT_FIXED64: begin
              decode_phase = PH_FIXED;
              remaining    = Fixed64Len;
            end
            WT_LEN:     decode_phase = PH_LENGTH;
            WT_FIXED32: begin
              decode_phase = PH_FIXED;
              remaining    = Fixed32Len;
            end
            default: ;
          endcase
          // still expecting a tag means the wire type was not recognized
          if (decode_phase == PH_TAG) begin
            raise_error(ERR_WIRE_TYPE, eom);
          end else if (eom) begin
            if (decode_phase == PH_FIXED) begin
              raise_error(ERR_PAST_END, eom);
            end else begin
              raise_error(ERR_TRUNCATED, eom);
            end
          end
        end
      end
      PH_VARINT, PH_LENGTH: begin
        st = take_varint(b);
        if (st == VARINT_LONG) begin
          raise_error(ERR_TOO_LONG, eom);
        end else if (st == VARINT_MORE) begin
          if (eom) raise_error(ERR_TRUNCATED, eom);
        end else begin
          v          = accum;
          accum      = '0;
          varint_len = '0;
          if (decode_phase == PH_VARINT) begin
            decode_phase = PH_TAG;
            push_token(KIND_SCALAR, held_field, held_wire, v, '0, NoError, eom);
          end else if (v == '0) begin
            decode_phase = PH_TAG;
            push_token(KIND_HEADER, held_field, WT_LEN, '0, '0, NoError, eom);
          end else if (eom) begin
            raise_error(ERR_PAST_END, eom);
          end else begin
            remaining    = v;
            decode_phase = PH_PAYLOAD;
            push_token(KIND_HEADER, held_field, WT_LEN, v, '0, NoError, eom);
          end
        end
      end
      PH_FIXED: begin
        // little-endian: byte index picks the lane
        accum |= ValueW'(b) << (8 * varint_len[2:0]);
        varint_len++;
        if (remaining != '0) remaining--;
        if (remaining == '0) begin
          v            = accum;
          accum        = '0;
          varint_len   = '0;
          decode_phase = PH_TAG;
          push_token(KIND_SCALAR, held_field, held_wire, v, '0, NoError, eom);
        end else if (eom) begin
          raise_error(ERR_PAST_END, eom);
        end
      end
      PH_PAYLOAD: begin
        if (remaining != '0) remaining--;
        if (remaining == '0) begin
          decode_phase = PH_TAG;
          push_token(KIND_PAYLOAD, held_field, WT_LEN, '0, b, NoError, eom);
        end else if (eom) begin
          raise_error(ERR_PAST_END, eom);
        end else begin
          push_token(KIND_PAYLOAD, held_field, WT_LEN, '0, b, NoError, eom);
        end
      end
      default: begin
        // dropping until the region ends
        if (eom) begin
          decode_phase = PH_TAG;
          accum        = '0;
          varint_len   = '0;
          remaining    = '0;
        end
      end
    endcase
  endtask

  always @(posedge clk_i) begin : watch_tokens
    result_t          got;
    result_t          want;
    logic [OutPadW-1:0] pad;
    if (!rst_ni) begin
      decode_phase = PH_TAG;
      accum        = '0;
      varint_len   = '0;
      held_field   = '0;
      held_wire    = '0;
      remaining    = '0;
      expected_tokens.delete();
      mismatches_o = 0;
    end else begin
      if (req_valid_i && req_ready_i) decode_byte(req_byte_i, req_last_i);
      if (tok_valid_i && tok_ready_i) begin
        got.kind           = kind_e'(tok_kind_i);
        got.field_number   = tok_data_i[FieldW-1:0];
        got.wire_type      = tok_data_i[FieldW +: WireW];
        got.value          = tok_data_i[FieldW+WireW +: ValueW];
        got.payload_byte   = tok_data_i[FieldW+WireW+ValueW +: ByteW];
        got.error_code     = err_e'(tok_data_i[FieldW+WireW+ValueW+ByteW +: CodeW]);
        got.end_of_message = tok_last_i;
        pad                = tok_data_i[OutDataW-1 -: OutPadW];
        if (expected_tokens.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%t unexpected token: %s", $realtime, token_text(got));
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want || pad !== '0) begin
            mismatches_o++;
            if (mismatches_o <= 10) begin
              $display("%t token mismatch, expected: %s", $realtime, token_text(want));
              $display("%t                 actual:   %s pad=%h", $realtime, token_text(got),
                       pad);
            end
          end
        end
      end
    end
    outstanding_o = expected_tokens.size();
  end

endmodule

[tb/protobuf_wire_tokenizer_test.sv]
`timescale 1ns / 100ps
module protobuf_wire_tokenizer_test;
  import pwt_pkg::*;

  localparam int IdleLimit   = 2000;
  localparam int StreamBytes = 1020;
  localparam int TailCycles  = 8;
  localparam int MaxPayload  = 40;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [ByteW-1:0]    s_tdata = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic [KindW-1:0]    m_tuser;
  logic                m_tlast;

  int         mismatches;
  int         outstanding;
  int         sent_bytes = 0;
  int         idle_cycles = 0;
  int         ready_run = 0;
  bit         burst = 1'b0;
  bit         region_closed;
  logic [7:0] region_bytes[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  protobuf_wire_tokenizer u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  pwt_token_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_valid_i   (s_tvalid),
    .req_ready_i   (s_tready),
    .req_byte_i    (s_tdata),
    .req_last_i    (s_tlast),
    .tok_valid_i   (m_tvalid),
    .tok_ready_i   (m_tready),
    .tok_data_i    (m_tdata),
    .tok_kind_i    (m_tuser),
    .tok_last_i    (m_tlast),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // mostly short idle spans, a few long ones
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin : drive_ready
    int r;
    if (ready_run == 0) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        m_tready <= 1'b1;
        ready_run = $urandom_range(1, 30);
      end else if (r < 70) begin
        m_tready <= 1'b1;
        ready_run = $urandom_range(100, 300);
      end else begin
        m_tready <= 1'b0;
        ready_run = idle_span();
      end
    end else begin
      ready_run--;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("** protobuf_wire_tokenizer: FAILED **");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eom);
    int gap;
    gap = (burst || $urandom_range(0, 99) < 55) ? 0 : idle_span();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eom;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    sent_bytes++;
  endtask

  task automatic send_region();
    for (int i = 0; i < region_bytes.size(); i++)
      send_byte(region_bytes[i], i == region_bytes.size() - 1);
  endtask

  task automatic wait_for_tokens();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  function automatic void append_byte(input logic [7:0] bt);
    region_bytes.insert(region_bytes.size(), bt);
  endfunction

  function automatic int pad_count();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 9) : 0;
  endfunction

  function automatic logic [ValueW-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return ValueW'($urandom_range(0, 300));
      5:       return ValueW'($urandom_range(0, 2097151));
      6, 7:    return {$urandom, $urandom};
      default: return ValueW'(1) << $urandom_range(0, 63);
    endcase
  endfunction

  function automatic logic [FieldW-1:0] rand_field();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return FieldW'($urandom_range(0, 15));
      6, 7, 8:          return FieldW'($urandom & 32'h1FFF_FFFF);
      default:          return FieldW'({$urandom, $urandom});
    endcase
  endfunction

  task automatic put_varint(input logic [ValueW-1:0] v, input int pad);
    int         n;
    logic [7:0] bt;
    n = 1;
    while (n < 10 && (v >> (7 * n)) != '0) n++;
    n = (n + pad > 10) ? 10 : n + pad;
    for (int i = 0; i < n; i++) begin
      bt = 8'((v >> (7 * i)) & ValueW'(8'h7F));
      if (i < n - 1) begin
        bt[7] = 1'b1;
      end else if (i == 9) begin
        // only bit 0 of the tenth byte lands in the value
        bt[6:1] = 6'($urandom);
      end
      append_byte(bt);
    end
  endtask

  task automatic put_tag(input logic [FieldW-1:0] fn, input logic [WireW-1:0] wt);
    put_varint({fn, wt}, pad_count());
  endtask

  task automatic put_random(input int n);
    repeat (n) append_byte(8'($urandom));
  endtask

  task automatic put_length_record(input logic [FieldW-1:0] fn);
    logic [ValueW-1:0] len;
    case ($urandom_range(0, 9))
      0, 1:          len = '0;
      2, 3, 4, 5, 6: len = ValueW'($urandom_range(1, 12));
      7:             len = ValueW'($urandom_range(13, MaxPayload));
      8:             len = {$urandom, $urandom};
      default:       len = '1;
    endcase
    put_tag(fn, WT_LEN);
    put_varint(len, pad_count());
    if (len <= ValueW'(MaxPayload)) begin
      put_random(int'(len));
    end else begin
      // payload runs past the region
      put_random($urandom_range(0, 5));
      region_closed = 1'b1;
    end
  endtask

  task automatic build_region();
    int                sel;
    int                cut;
    int                records;
    logic [FieldW-1:0] fn;
    logic [WireW-1:0]  wt;
    region_bytes.delete();
    region_closed = 1'b0;
    records = $urandom_range(1, 4);
    for (int k = 0; k < records && !region_closed; k++) begin
      sel = $urandom_range(0, 99);
      fn  = rand_field();
      if (sel < 30) begin
        put_tag(fn, WT_VARINT);
        put_varint(rand_value(), pad_count());
      end else if (sel < 45) begin
        put_tag(fn, WT_FIXED32);
        put_random(4);
      end else if (sel < 55) begin
        put_tag(fn, WT_FIXED64);
        put_random(8);
      end else if (sel < 82) begin
        put_length_record(fn);
      end else if (sel < 88) begin
        do wt = WireW'($urandom); while (wt inside {WT_VARINT, WT_FIXED64, WT_LEN, WT_FIXED32});
        put_tag(fn, wt);
        put_random($urandom_range(0, 4));
        region_closed = 1'b1;
      end else if (sel < 94) begin
        // overlong varint, in tag or value position
        if ($urandom_range(0, 1) == 1) put_tag(fn, WT_VARINT);
        repeat ($urandom_range(10, 12)) append_byte(8'h80 | 8'($urandom));
        region_closed = 1'b1;
      end else begin
        put_random($urandom_range(1, 6));
        region_closed = 1'b1;
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, region_bytes.size());
      while (region_bytes.size() > cut) void'(region_bytes.pop_back());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // tag ends the region: varint body missing
    region_bytes = '{8'h08};
    send_region();
    // tag ends the region: fixed32 body missing
    region_bytes = '{8'h2D};
    send_region();
    // unknown wire type, then dropped bytes
    region_bytes = '{8'h0F, 8'hFF, 8'h00};
    send_region();
    // varint still continuing at the last byte
    region_bytes = '{8'h08, 8'h80};
    send_region();
    // empty payload, then a one-byte payload closing the region
    region_bytes = '{8'h1A, 8'h00, 8'h1A, 8'h01, 8'hFF};
    send_region();
    // payload cut off after the header went out
    region_bytes = '{8'h12, 8'h02, 8'h55};
    send_region();
    // nonzero length completed on the last byte
    region_bytes = '{8'h12, 8'h01};
    send_region();
    // ten continuation bytes, the tenth being last
    region_bytes.delete();
    repeat (10) append_byte(8'h80);
    send_region();
    wait_for_tokens();

    while (sent_bytes < StreamBytes) begin
      build_region();
      burst = ($urandom_range(0, 3) == 0);
      send_region();
      if ($urandom_range(0, 24) == 0) wait_for_tokens();
    end
    wait_for_tokens();
    repeat (TailCycles) @(negedge clk);

    if (mismatches == 0) begin
      $display("** protobuf_wire_tokenizer: PASSED **");
    end else begin
      $display("** protobuf_wire_tokenizer: FAILED **");
    end
    $finish;
  end

endmodule

[protobuf_wire_tokenizer.f]
rtl/pwt_pkg.sv
rtl/pwt_in_reg.sv
rtl/pwt_decode.sv
rtl/pwt_out_reg.sv
rtl/protobuf_wire_tokenizer.sv
tb/pwt_token_checker.sv
tb/protobuf_wire_tokenizer_test.sv
